// ----- rtl/event_frame_receiver_core_assert.svh -----
// Assertion macros for the event frame receiver core.
`ifndef EVENT_FRAME_RECEIVER_CORE_ASSERT_SVH
`define EVENT_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, clocked on clk_i, disabled in reset.
`define EFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, clocked on clk_i, disabled in reset.
`define EFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EFR_ASSERT_IMPL(lbl, ante, cons, msg)
`define EFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/efr_pkg.sv -----
// Package with frame bytes, result kinds and parser phase codes.
`timescale 1ns / 1ps
`default_nettype none
package efr_pkg;

  localparam logic [7:0] START_BYTE  = 8'hFF;
  localparam logic [7:0] STOP_FIRST  = 8'hAA;
  localparam logic [7:0] STOP_SECOND = 8'h55;

  localparam int unsigned KindW  = 3;
  localparam int unsigned PhaseW = 4;

  localparam logic [KindW-1:0] KIND_EVENT       = 3'd0;
  localparam logic [KindW-1:0] KIND_ZERO_SOURCE = 3'd1;
  localparam logic [KindW-1:0] KIND_ZERO_ID     = 3'd2;
  localparam logic [KindW-1:0] KIND_BAD_STOP_A  = 3'd3;
  localparam logic [KindW-1:0] KIND_BAD_STOP_B  = 3'd4;

  localparam logic [PhaseW-1:0] PH_IDLE      = 4'd0;
  localparam logic [PhaseW-1:0] PH_SOURCE    = 4'd1;
  localparam logic [PhaseW-1:0] PH_ID_HIGH   = 4'd2;
  localparam logic [PhaseW-1:0] PH_ID_LOW    = 4'd3;
  localparam logic [PhaseW-1:0] PH_VALUE     = 4'd4;
  localparam logic [PhaseW-1:0] PH_STOP_A    = 4'd5;
  localparam logic [PhaseW-1:0] PH_STOP_B    = 4'd6;
  localparam logic [PhaseW-1:0] PH_HUNT      = 4'd7;
  localparam logic [PhaseW-1:0] PH_HUNT_PAIR = 4'd8;

endpackage
`default_nettype wire

// ----- rtl/event_frame_receiver_core.sv -----
// Event frame receiver: byte-stream parser that recovers seven-byte event frames.
//
// Input channel: rx_byte_i with in_valid_i / in_stall_o, one byte per transaction.
// Output channel: kind_o, source_id_o, event_id_o, event_value_o with
// out_valid_o / out_stall_i, one event or error result per transaction.
// A frame is 0xFF, source, event id high, event id low, value, 0xAA, 0x55.
// Errors (zero source, zero event id, bad stop byte) give one result and
// start a hunt for the 0xAA 0x55 pair before the next frame is searched.
// Throughput: one byte per cycle while out_stall_i stays low. A byte is
// captured in the input register, parsed from there once the output register
// is free, and its result, if any, lands in the output register.
// A result waits in the output register while out_stall_i is high; the input
// register still takes a byte if it is empty, then in_stall_o rises until
// the output register frees up.
// Reset clears both registers and returns the parser to idle, with the
// held source, event id and value at zero.
`timescale 1ns / 1ps
`default_nettype none
`include "event_frame_receiver_core_assert.svh"
module event_frame_receiver_core
  import efr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [KindW-1:0]      kind_o,
  output logic [7:0]            source_id_o,
  output logic [15:0]           event_id_o,
  output logic [7:0]            event_value_o
);

  logic              byte_valid_q;
  logic [7:0]        byte_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [7:0]        src_q, src_d;
  logic [15:0]       id_q, id_d;
  logic [7:0]        val_q, val_d;
  logic              out_valid_q;
  logic [KindW-1:0]  kind_q, kind_d;
  logic [7:0]        rsrc_q, rsrc_d;
  logic [15:0]       rid_q, rid_d;
  logic [7:0]        rval_q, rval_d;
  logic              emit;
  logic              out_free;
  logic              proc;
  logic              in_take;
  logic [15:0]       id_low;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = byte_valid_q && out_free;
  assign in_stall_o = byte_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign id_low     = {id_q[15:8], byte_q};

  always_comb begin
    phase_d = phase_q;
    src_d   = src_q;
    id_d    = id_q;
    val_d   = val_q;
    emit    = 1'b0;
    kind_d  = KIND_EVENT;
    rsrc_d  = src_q;
    rid_d   = id_q;
    rval_d  = val_q;
    case (phase_q)
      PH_SOURCE: begin
        if (byte_q == 8'h00) begin
          phase_d = PH_HUNT;
          emit    = 1'b1;
          kind_d  = KIND_ZERO_SOURCE;
          rsrc_d  = 8'h00;
          rid_d   = 16'h0000;
          rval_d  = 8'h00;
        end else begin
          src_d   = byte_q;
          phase_d = PH_ID_HIGH;
        end
      end
      PH_ID_HIGH: begin
        id_d    = {byte_q, 8'h00};
        phase_d = PH_ID_LOW;
      end
      PH_ID_LOW: begin
        id_d = id_low;
        if (id_low == 16'h0000) begin
          phase_d = PH_HUNT;
          emit    = 1'b1;
          kind_d  = KIND_ZERO_ID;
          rid_d   = 16'h0000;
          rval_d  = 8'h00;
        end else begin
          phase_d = PH_VALUE;
        end
      end
      PH_VALUE: begin
        val_d   = byte_q;
        phase_d = PH_STOP_A;
      end
      PH_STOP_A: begin
        if (byte_q != STOP_FIRST) begin
          phase_d = PH_HUNT;
          emit    = 1'b1;
          kind_d  = KIND_BAD_STOP_A;
        end else begin
          phase_d = PH_STOP_B;
        end
      end
      PH_STOP_B: begin
        emit = 1'b1;
        if (byte_q != STOP_SECOND) begin
          phase_d = PH_HUNT;
          kind_d  = KIND_BAD_STOP_B;
        end else begin
          phase_d = PH_IDLE;
          kind_d  = KIND_EVENT;
        end
      end
      PH_HUNT: begin
        if (byte_q == STOP_FIRST) begin
          phase_d = PH_HUNT_PAIR;
        end
      end
      PH_HUNT_PAIR: begin
        phase_d = (byte_q == STOP_SECOND) ? PH_IDLE : PH_HUNT;
      end
      default: begin
        if (byte_q == START_BYTE) begin
          src_d   = 8'h00;
          id_d    = 16'h0000;
          val_d   = 8'h00;
          phase_d = PH_SOURCE;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= rx_byte_i;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      src_q   <= 8'h00;
      id_q    <= 16'h0000;
      val_q   <= 8'h00;
    end else if (proc) begin
      phase_q <= phase_d;
      src_q   <= src_d;
      id_q    <= id_d;
      val_q   <= val_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      kind_q <= kind_d;
      rsrc_q <= rsrc_d;
      rid_q  <= rid_d;
      rval_q <= rval_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign source_id_o   = rsrc_q;
  assign event_id_o    = rid_q;
  assign event_value_o = rval_q;

  `EFR_ASSERT_IMPL(a_phase_range, 1'b1, phase_q <= PH_HUNT_PAIR, "parser phase out of range")
  `EFR_ASSERT_IMPL(a_event_ids, out_valid_o && kind_o == KIND_EVENT,
                   source_id_o != 8'h00 && event_id_o != 16'h0000, "event with zero id")
  `EFR_ASSERT_IMPL(a_kind_range, out_valid_o, kind_o <= KIND_BAD_STOP_B, "result kind out of range")
  `EFR_ASSERT_NEXT(a_error_hunts, proc && emit && kind_d != KIND_EVENT,
                   phase_q == PH_HUNT && out_valid_q, "error result without hunt")

endmodule
`default_nettype wire

// ----- sim/tb_event_frame_receiver_core.sv -----
// Testbench for event_frame_receiver_core: random byte streams checked against a frame parser model.
`timescale 1ns / 1ps
module tb_event_frame_receiver_core;
  import efr_pkg::*;

  localparam int ItemTarget = 1900;
  localparam int IdleLimit  = 3000;
  localparam int HoldCycles = 120;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [7:0]       source_id;
    logic [15:0]      event_id;
    logic [7:0]       event_value;
  } frame_result_t;

  class frame_scoreboard;
    logic [PhaseW-1:0] phase;
    logic [7:0]        src_q;
    logic [15:0]       id_q;
    logic [7:0]        val_q;
    frame_result_t     pending_q[$];
    int                bytes_in;
    int                results_in;
    int                mismatches;
    int                kind_cnt[5];

    function new();
      phase      = PH_IDLE;
      src_q      = '0;
      id_q       = '0;
      val_q      = '0;
      bytes_in   = 0;
      results_in = 0;
      mismatches = 0;
      foreach (kind_cnt[k]) kind_cnt[k] = 0;
    endfunction

    function void push_result(logic [KindW-1:0] kind, logic [7:0] s, logic [15:0] id,
                              logic [7:0] v);
      frame_result_t r;
      r.kind        = kind;
      r.source_id   = s;
      r.event_id    = id;
      r.event_value = v;
      pending_q.push_back(r);
    endfunction

    // Advance the parser by one accepted byte.
    function void note_byte(logic [7:0] b);
      bytes_in++;
      case (phase)
        PH_SOURCE: begin
          if (b == 8'h00) begin
            phase = PH_HUNT;
            push_result(KIND_ZERO_SOURCE, 8'h00, 16'h0000, 8'h00);
          end else begin
            src_q = b;
            phase = PH_ID_HIGH;
          end
        end
        PH_ID_HIGH: begin
          id_q  = {b, 8'h00};
          phase = PH_ID_LOW;
        end
        PH_ID_LOW: begin
          id_q = {id_q[15:8], b};
          if (id_q == 16'h0000) begin
            phase = PH_HUNT;
            push_result(KIND_ZERO_ID, src_q, 16'h0000, 8'h00);
          end else begin
            phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          val_q = b;
          phase = PH_STOP_A;
        end
        PH_STOP_A: begin
          if (b != STOP_FIRST) begin
            phase = PH_HUNT;
            push_result(KIND_BAD_STOP_A, src_q, id_q, val_q);
          end else begin
            phase = PH_STOP_B;
          end
        end
        PH_STOP_B: begin
          if (b != STOP_SECOND) begin
            phase = PH_HUNT;
            push_result(KIND_BAD_STOP_B, src_q, id_q, val_q);
          end else begin
            phase = PH_IDLE;
            push_result(KIND_EVENT, src_q, id_q, val_q);
          end
        end
        PH_HUNT: begin
          if (b == STOP_FIRST) phase = PH_HUNT_PAIR;
        end
        PH_HUNT_PAIR: begin
          phase = (b == STOP_SECOND) ? PH_IDLE : PH_HUNT;
        end
        default: begin
          if (b == START_BYTE) begin
            src_q = '0;
            id_q  = '0;
            val_q = '0;
            phase = PH_SOURCE;
          end else begin
            phase = PH_IDLE;
          end
        end
      endcase
    endfunction

    function void check_result(logic [KindW-1:0] kind, logic [7:0] s, logic [15:0] id,
                               logic [7:0] v);
      frame_result_t want;
      results_in++;
      if (pending_q.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: unexpected result kind %0d src %02h id %04h val %02h",
                   kind, s, id, v);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      if (kind < 5) kind_cnt[kind]++;
      if (want.kind !== kind || want.source_id !== s || want.event_id !== id ||
          want.event_value !== v) begin
        if (mismatches < 10) begin
          $display("ERROR: result %0d expected kind %0d src %02h id %04h val %02h",
                   results_in, want.kind, want.source_id, want.event_id, want.event_value);
          $display("       got kind %0d src %02h id %04h val %02h", kind, s, id, v);
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [7:0]       rx_byte_i   = 8'h00;
  logic             out_stall_i = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [KindW-1:0] kind_o;
  logic [7:0]       source_id_o;
  logic [15:0]      event_id_o;
  logic [7:0]       event_value_o;

  frame_scoreboard sb;
  int  calm_left     = 0;
  bit  hold_req      = 1'b0;
  int  hold_left     = 0;
  int  stall_left    = 0;
  int  rx_cycles     = 0;
  int  in_stalls     = 0;
  int  idle_cycles   = 0;

  event_frame_receiver_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .source_id_o   (source_id_o),
    .event_id_o    (event_id_o),
    .event_value_o (event_value_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Random byte biased toward the framing values.
  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return START_BYTE;
      2:       return STOP_FIRST;
      3:       return STOP_SECOND;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (calm_left > 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do begin
      @(posedge clk_i);
      if (in_stall_o) in_stalls++;
    end while (in_stall_o);
    sb.note_byte(b);
    if (calm_left > 0) calm_left--;
  endtask

  task automatic send_frame(input logic [7:0] src, input logic [15:0] id,
                            input logic [7:0] val, input logic [7:0] s1,
                            input logic [7:0] s2);
    send_byte(START_BYTE);
    send_byte(src);
    send_byte(id[15:8]);
    send_byte(id[7:0]);
    send_byte(val);
    send_byte(s1);
    send_byte(s2);
  endtask

  // Result side: check each transaction, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycles++;
      if (out_valid_o && !out_stall_i)
        sb.check_result(kind_o, source_id_o, event_id_o, event_value_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ((rx_cycles % 1024) < 160 || $urandom_range(0, 2) != 0) begin
        out_stall_i <= 1'b0;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                 IdleLimit, sb.pending());
        $display("event_frame_receiver_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  opening[];
    bit          pressure_done;
    int          r;
    logic [7:0]  src;
    logic [7:0]  val;
    logic [7:0]  bad;
    logic [15:0] id;

    opening = '{
      8'h00, 8'h5A,
      START_BYTE, 8'h01, 8'h00, 8'h01, 8'h00, STOP_FIRST, STOP_SECOND,
      START_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, STOP_FIRST, STOP_SECOND,
      START_BYTE, 8'h00, STOP_FIRST, STOP_FIRST, STOP_SECOND, START_BYTE, STOP_FIRST,
      STOP_SECOND,
      START_BYTE, 8'h05, 8'h00, 8'h00, STOP_FIRST, STOP_SECOND,
      START_BYTE, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, STOP_FIRST, STOP_SECOND,
      START_BYTE, 8'h80, 8'h80, 8'h00, 8'h7F, STOP_FIRST, STOP_FIRST, STOP_FIRST,
      STOP_SECOND
    };
    sb = new();
    pressure_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_byte(opening[i]);

    while (sb.bytes_in < ItemTarget) begin
      if (!pressure_done && sb.bytes_in >= 800) begin
        pressure_done = 1'b1;
        hold_req      = 1'b1;
        calm_left     = 150;
      end else if (calm_left == 0 && $urandom_range(0, 59) == 0) begin
        calm_left = 80;
      end
      src = 8'($urandom_range(1, 255));
      do id = {data_byte(), data_byte()}; while (id == 16'h0000);
      val = data_byte();
      r   = $urandom_range(0, 99);
      if (r < 60) begin
        send_frame(src, id, val, STOP_FIRST, STOP_SECOND);
      end else if (r < 68) begin
        send_frame(8'h00, id, val, STOP_FIRST, STOP_SECOND);
      end else if (r < 76) begin
        send_frame(src, 16'h0000, val, STOP_FIRST, STOP_SECOND);
      end else if (r < 82) begin
        do bad = data_byte(); while (bad == STOP_FIRST);
        send_frame(src, id, val, bad, data_byte());
        send_byte(STOP_FIRST);
        send_byte(STOP_SECOND);
      end else if (r < 88) begin
        do bad = data_byte(); while (bad == STOP_SECOND);
        send_frame(src, id, val, STOP_FIRST, bad);
        send_byte(STOP_FIRST);
        send_byte(STOP_SECOND);
      end else if (r < 95) begin
        repeat ($urandom_range(1, 6)) send_byte(data_byte());
      end else begin
        // cut-off frame, the next start byte lands inside it
        send_byte(START_BYTE);
        repeat ($urandom_range(1, 4)) send_byte(data_byte());
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Covered %0d bytes, %0d results: %0d events, %0d zero source, %0d zero id,",
             sb.bytes_in, sb.results_in, sb.kind_cnt[KIND_EVENT],
             sb.kind_cnt[KIND_ZERO_SOURCE], sb.kind_cnt[KIND_ZERO_ID]);
    $display("%0d bad first stop, %0d bad second stop; input stalled %0d cycles.",
             sb.kind_cnt[KIND_BAD_STOP_A], sb.kind_cnt[KIND_BAD_STOP_B], in_stalls);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("event_frame_receiver_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("event_frame_receiver_core regression: fail");
    end
    $finish;
  end

endmodule
